[rtl/core/tpmm_pkg.sv]
// Shared types, constants and lookup tables for the touch pad to MIDI mapper.
`default_nettype none

package tpmm_pkg;

  // Pad count and field widths
  localparam int PAD_COUNT = 32;
  localparam int PAD_W     = 5;
  localparam int NOTE_W    = 7;
  localparam int VEL_IDX_W = 3;

  // MIDI status bytes and fixed values
  localparam logic [7:0] STATUS_NOTE    = 8'h90;
  localparam logic [7:0] STATUS_PROGRAM = 8'hc0;
  localparam logic [7:0] STATUS_CTRL    = 8'hb0;
  localparam logic [6:0] CTRL_ON_VALUE  = 7'h7f;
  localparam logic [6:0] PROGRAM_MAX    = 7'd127;
  localparam logic [2:0] VEL_IDX_MAX    = 3'd4;

  // Message lengths
  localparam logic [1:0] LEN_NONE    = 2'd0;
  localparam logic [1:0] LEN_PROGRAM = 2'd2;
  localparam logic [1:0] LEN_FULL    = 2'd3;

  // Command codes
  localparam logic CMD_TOUCH_ON  = 1'b0;
  localparam logic CMD_TOUCH_OFF = 1'b1;

  // Configuration register indexes
  localparam logic CFG_LAYOUT_MODE = 1'b0;
  localparam logic CFG_START_VEL   = 1'b1;

  // Step arguments of control pads
  localparam logic [7:0] STEP_UP   = 8'h01;
  localparam logic [7:0] STEP_DOWN = 8'hff;

  typedef enum logic [2:0] {
    ROLE_KEY  = 3'd0,
    ROLE_PROG = 3'd1,
    ROLE_OCT  = 3'd2,
    ROLE_VEL  = 3'd3,
    ROLE_CTRL = 3'd4
  } pad_role_t;

  typedef struct packed {
    pad_role_t  role;
    logic [7:0] arg;
  } pad_entry_t;

  // Pad role lookup for both layouts
  function automatic pad_entry_t pad_rom(input logic mode, input logic [PAD_W-1:0] pad);
    pad_entry_t e;
    e.role = ROLE_KEY;
    e.arg  = 8'd60 + {3'd0, pad};
    if (mode) begin
      if (pad < 5'd16) begin
        e.arg = 8'd48 + {3'd0, pad};
      end else if (pad < 5'd24) begin
        e.arg = 8'd87 - {3'd0, pad};
      end else begin
        case (pad)
          5'd24: begin e.role = ROLE_OCT;  e.arg = STEP_UP;   end
          5'd25: begin e.role = ROLE_VEL;  e.arg = STEP_UP;   end
          5'd26: begin e.role = ROLE_VEL;  e.arg = STEP_DOWN; end
          5'd27: begin e.role = ROLE_PROG; e.arg = STEP_UP;   end
          5'd28: begin e.role = ROLE_PROG; e.arg = STEP_DOWN; end
          5'd29: begin e.role = ROLE_CTRL; e.arg = STEP_UP;   end
          5'd30: begin e.role = ROLE_OCT;  e.arg = STEP_DOWN; end
          default: begin e.role = ROLE_KEY; e.arg = 8'd72; end
        endcase
      end
    end
    return e;
  endfunction

  // Velocity by index
  function automatic logic [6:0] vel_rom(input logic [VEL_IDX_W-1:0] idx);
    logic [6:0] v;
    case (idx)
      3'd0:    v = 7'd60;
      3'd1:    v = 7'd80;
      3'd2:    v = 7'd100;
      3'd3:    v = 7'd114;
      default: v = 7'd127;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/touch_pad_to_midi_mapper_unit.sv]
// Touch pad to MIDI mapper: pad event decode, held-note store and MIDI message build.
// An accepted transaction is registered in the read stage, then in the output register.
// Throughput: one transaction per cycle unless the output stalls; the held-note memory is
// read on capture and written back, with a bypass when consecutive events hit one pad.
// Reset: synchronous, active high; clears octave, program, velocity index (to 4), layout,
// the held-note valid bits (unwritten notes read as zero) and both pipeline valids.
`default_nettype none

module touch_pad_to_midi_mapper_unit import tpmm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Touch event channel
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic                 command,
  input  wire logic [PAD_W-1:0]     pad,
  // Result channel
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic                      send,
  output logic [1:0]                byte_count,
  output logic [7:0]                status_byte,
  output logic [6:0]                data_one,
  output logic [6:0]                data_two,
  output logic                      indicator_pulse,
  output logic signed [1:0]         octave_now,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [VEL_IDX_W-1:0] cfg_data
);

  // Architectural state
  logic                 layout_mode;
  logic signed [1:0]    octave;
  logic [VEL_IDX_W-1:0] vel_idx;
  logic [6:0]           program_num;
  logic [NOTE_W-1:0]    held_mem [2**PAD_W];
  logic [2**PAD_W-1:0]  held_valid;

  // Read stage registers
  logic                 s1_valid;
  logic                 s1_cmd;
  logic [PAD_W-1:0]     s1_pad;
  logic [NOTE_W-1:0]    s1_rd;
  logic                 s1_fwd;
  logic [NOTE_W-1:0]    s1_fwd_data;

  // Handshake and write-back controls
  logic                 out_free;
  logic                 s1_adv;
  logic                 accept;
  logic                 cfg_write;
  logic                 wr_en;
  logic [NOTE_W-1:0]    wr_data;

  // Result stage logic
  pad_entry_t           entry;
  logic                 up;
  logic                 in_range;
  logic [NOTE_W-1:0]    held_val;
  logic [6:0]           oct_add;
  logic signed [1:0]    octave_next;
  logic [VEL_IDX_W-1:0] vel_idx_next;
  logic [6:0]           program_next;
  logic                 send_next;
  logic [1:0]           count_next;
  logic [7:0]           status_next;
  logic [6:0]           d1_next;
  logic [6:0]           d2_next;
  logic                 pulse_next;
  logic [VEL_IDX_W-1:0] cfg_vel;

  assign out_free   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign cfg_vel    = (cfg_data > VEL_IDX_MAX) ? VEL_IDX_MAX : cfg_data;

  // Capture the transaction and read its held note
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_cmd      <= command;
      s1_pad      <= pad;
      s1_fwd      <= wr_en && (s1_pad == pad);
      s1_fwd_data <= wr_data;
    end
  end

  // Held-note memory, read before write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      held_mem[s1_pad] <= wr_data;
    end
    if (accept) begin
      s1_rd <= held_mem[pad];
    end
  end

  // Decode the pad and build the message
  always_comb begin
    entry    = pad_rom(layout_mode, s1_pad);
    up       = (entry.arg == STEP_UP);
    in_range = (int'(s1_pad) < PAD_COUNT);
    held_val = s1_fwd ? s1_fwd_data : (held_valid[s1_pad] ? s1_rd : '0);
    case (octave)
      2'sd1:   oct_add = 7'd12;
      -2'sd1:  oct_add = 7'd116;
      default: oct_add = 7'd0;
    endcase

    octave_next  = octave;
    vel_idx_next = vel_idx;
    program_next = program_num;
    send_next    = 1'b0;
    count_next   = LEN_NONE;
    status_next  = '0;
    d1_next      = '0;
    d2_next      = '0;
    pulse_next   = 1'b0;
    wr_en        = 1'b0;
    wr_data      = entry.arg[6:0] + oct_add;

    if (s1_adv && in_range) begin
      if (s1_cmd == CMD_TOUCH_ON) begin
        case (entry.role)
          ROLE_KEY: begin
            wr_en       = 1'b1;
            send_next   = 1'b1;
            count_next  = LEN_FULL;
            status_next = STATUS_NOTE;
            d1_next     = wr_data;
            d2_next     = vel_rom(vel_idx);
            pulse_next  = 1'b1;
          end
          ROLE_PROG: begin
            if (up && program_num < PROGRAM_MAX) begin
              program_next = program_num + 7'd1;
            end else if (!up && program_num != 7'd0) begin
              program_next = program_num - 7'd1;
            end
            send_next   = 1'b1;
            count_next  = LEN_PROGRAM;
            status_next = STATUS_PROGRAM;
            d1_next     = program_next;
            pulse_next  = 1'b1;
          end
          ROLE_OCT: begin
            if (octave == 2'sd0) begin
              octave_next = up ? 2'sd1 : -2'sd1;
            end else begin
              octave_next = 2'sd0;
            end
          end
          ROLE_VEL: begin
            if (up && vel_idx < VEL_IDX_MAX) begin
              vel_idx_next = vel_idx + 3'd1;
              pulse_next   = 1'b1;
            end else if (!up && vel_idx != 3'd0) begin
              vel_idx_next = vel_idx - 3'd1;
              pulse_next   = 1'b1;
            end
          end
          default: begin
            send_next   = 1'b1;
            count_next  = LEN_FULL;
            status_next = STATUS_CTRL;
            d1_next     = entry.arg[6:0];
            d2_next     = CTRL_ON_VALUE;
            pulse_next  = 1'b1;
          end
        endcase
      end else if (entry.role == ROLE_KEY) begin
        send_next   = 1'b1;
        count_next  = LEN_FULL;
        status_next = STATUS_NOTE;
        d1_next     = held_val;
        pulse_next  = 1'b1;
      end else if (entry.role == ROLE_CTRL) begin
        send_next   = 1'b1;
        count_next  = LEN_FULL;
        status_next = STATUS_CTRL;
        d1_next     = entry.arg[6:0];
        pulse_next  = 1'b1;
      end
    end
  end

  // Update state, held-note valid bits and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode <= 1'b0;
      octave      <= 2'sd0;
      vel_idx     <= VEL_IDX_MAX;
      program_num <= 7'd0;
      held_valid  <= '0;
    end else begin
      if (s1_adv) begin
        octave      <= octave_next;
        vel_idx     <= vel_idx_next;
        program_num <= program_next;
      end
      if (wr_en) begin
        held_valid[s1_pad] <= 1'b1;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_LAYOUT_MODE: layout_mode <= cfg_data[0];
          CFG_START_VEL:   vel_idx     <= cfg_vel;
          default:         layout_mode <= layout_mode;
        endcase
      end
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
    if (s1_adv) begin
      send            <= send_next;
      byte_count      <= count_next;
      status_byte     <= status_next;
      data_one        <= d1_next;
      data_two        <= d2_next;
      indicator_pulse <= pulse_next;
      octave_now      <= octave_next;
    end
  end

`ifndef SYNTHESIS
  // A stall means both stages hold a transaction
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid))
    else $error("input stalled with a free pipeline slot");

  // A written note is marked valid on the next cycle
  a_wr_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> held_valid[$past(s1_pad)])
    else $error("held-note valid bit not set after write");

  // Velocity index stays within the table and octave never reaches -2
  a_vel_range: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (vel_idx <= VEL_IDX_MAX && octave != -2'sd2))
    else $error("velocity index or octave out of range after update");
`endif

endmodule

`default_nettype wire
